### design/zsb_pkg.sv
// ----------------------------------------------------------------------------
// zsb_pkg: shared types and constants for the zoomed sprite blitter
// Screen geometry, color key, zoom limit and the job record that is passed
// from the pixel front end to the write generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zsb_pkg;

  // Screen and sprite geometry
  localparam int unsigned SCREEN_WIDTH = 320;
  localparam int unsigned MAX_ZOOM     = 8;
  localparam logic [7:0]  COLOR_KEY    = 8'hFF;

  // Field widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned ZOOM_W  = 4;
  // Offset inside one block, 0 .. MAX_ZOOM-1
  localparam int unsigned OFS_W   = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
  // row*zoom and column*zoom products
  localparam int unsigned ROWZ_W  = ROW_W + OFS_W;
  localparam int unsigned COLZ_W  = COL_W + OFS_W;

  // Job queue depth
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register indexes of the configuration port
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ZOOM   = 2'd3;

  // One visible source pixel, ready for block expansion
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [ROWZ_W-1:0]  row_z;    // row * zoom
    logic [COLZ_W-1:0]  col_z;    // column * zoom
    logic [OFS_W-1:0]   zoom_m1;  // zoom - 1
  } zsb_job_t;

endpackage

`default_nettype wire

### design/zoomed_sprite_blit_color_key.sv
// ----------------------------------------------------------------------------
// zoomed_sprite_blit_color_key: scaled sprite blit with transparent color key
// Turns each non-transparent source pixel into a zoom-by-zoom block of
// framebuffer writes, row by row, flagging the last write of each block.
//
//  Channel   Dir  Transaction                tdata / tuser / tlast
//  s_axis    in   one source pixel           tdata[7:0] pixel_color,
//                                            tuser start_of_image
//  m_axis    out  one framebuffer write      tdata[15:0] write_address,
//                                            tdata[23:16] write_color,
//                                            tlast last_write
//  cfg       in   one register write         cfg_index_i, cfg_data_i
//
// A visible pixel passes through job fetch and origin setup in the write
// generator, then gets one write per cycle while m_axis is ready; transparent
// pixels are taken at one per cycle while the 4-entry job queue has room.
// Reset clears the position counters, queue and sequencer; registers reset
// to base 0, width 16, height 16, zoom 1.
// A stalled m_axis holds the write generator; s_axis stalls only when the
// job queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zoomed_sprite_blit_color_key (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_color
  input  wire logic        s_axis_tuser,   // [0] start_of_image
  // Write output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] write_address, [23:16] write_color
  output logic             m_axis_tlast,   // last_write
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import zsb_pkg::*;

  logic [ADDR_W-1:0]  base_q;
  logic [COL_W-1:0]   width_q;
  logic [ROW_W-1:0]   height_q;
  logic [ZOOM_W-1:0]  zoom_q;

  zsb_job_t           push_job, pop_job;
  logic               push, pop, fifo_full, fifo_empty;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COLOR_W-1:0] wr_color;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      width_q  <= COL_W'(16);
      height_q <= ROW_W'(16);
      zoom_q   <= ZOOM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BASE:   base_q   <= cfg_data_i[ADDR_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[COL_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
        REG_ZOOM:   zoom_q   <= cfg_data_i[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: position tracking and transparency filter
  zsb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .pixel_color_i    (s_axis_tdata),
    .start_of_image_i (s_axis_tuser),
    .image_width_i    (width_q),
    .image_height_i   (height_q),
    .zoom_factor_i    (zoom_q),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  // Job queue
  zsb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (fifo_empty)
  );

  // Back end: block write generation
  zsb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_index_i    (base_q),
    .fifo_empty_i    (fifo_empty),
    .pop_o           (pop),
    .job_i           (pop_job),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .write_address_o (wr_addr),
    .write_color_o   (wr_color),
    .last_write_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {wr_color, wr_addr};

endmodule

`default_nettype wire

### design/zsb_fifo.sv
// ----------------------------------------------------------------------------
// zsb_fifo: job queue between front end and write generator
// Small register FIFO; lets the pixel intake and the write stream stall
// independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zsb_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire zsb_pkg::zsb_job_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output zsb_pkg::zsb_job_t      pop_data_o,
  output logic                   empty_o
);
  import zsb_pkg::*;

  zsb_job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### design/zsb_front.sv
// ----------------------------------------------------------------------------
// zsb_front: pixel intake and classification
// Tracks the column and row of each source pixel, drops transparent pixels
// and queues the visible ones with their scaled position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zsb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [zsb_pkg::COLOR_W-1:0]   pixel_color_i,
  input  wire logic                          start_of_image_i,
  input  wire logic [zsb_pkg::COL_W-1:0]     image_width_i,
  input  wire logic [zsb_pkg::ROW_W-1:0]     image_height_i,
  input  wire logic [zsb_pkg::ZOOM_W-1:0]    zoom_factor_i,
  input  wire logic                          fifo_full_i,
  output logic                               push_o,
  output zsb_pkg::zsb_job_t                  job_o
);
  import zsb_pkg::*;

  logic [COL_W-1:0]  col_q, col_d, col_cur, col_inc;
  logic [ROW_W-1:0]  row_q, row_d, row_cur, row_inc;
  logic [ZOOM_W-1:0] zoom_eff;
  logic              accept, visible;

  assign s_axis_tready = !fifo_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Zoom saturates at the largest block size
  assign zoom_eff = (zoom_factor_i > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_factor_i;
  assign visible  = (pixel_color_i != COLOR_KEY) && (zoom_eff != '0);

  // Position of this pixel; start flag restarts the image
  assign col_cur = start_of_image_i ? '0 : col_q;
  assign row_cur = start_of_image_i ? '0 : row_q;
  assign col_inc = col_cur + 1'b1;
  assign row_inc = row_cur + 1'b1;

  // Position of the next pixel
  always_comb begin
    col_d = col_inc;
    row_d = row_cur;
    if (col_inc == '0 || col_inc >= image_width_i) begin
      col_d = '0;
      row_d = row_inc;
      if (row_inc == '0 || row_inc >= image_height_i) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Queue entry for a visible pixel
  assign push_o        = accept && visible;
  assign job_o.color   = pixel_color_i;
  assign job_o.row_z   = ROWZ_W'(row_cur) * ROWZ_W'(zoom_eff);
  assign job_o.col_z   = COLZ_W'(col_cur) * COLZ_W'(zoom_eff);
  assign job_o.zoom_m1 = OFS_W'(zoom_eff - 1'b1);

endmodule

`default_nettype wire

### design/zsb_back.sv
// ----------------------------------------------------------------------------
// zsb_back: block write generator
// Takes one queued pixel, computes its block origin and steps through
// the zoom-by-zoom block, one framebuffer write per cycle while not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zsb_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [zsb_pkg::ADDR_W-1:0]   base_index_i,
  input  wire logic                         fifo_empty_i,
  output logic                              pop_o,
  input  wire zsb_pkg::zsb_job_t            job_i,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [zsb_pkg::ADDR_W-1:0]        write_address_o,
  output logic [zsb_pkg::COLOR_W-1:0]       write_color_o,
  output logic                              last_write_o
);
  import zsb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_e;

  localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(SCREEN_WIDTH);

  state_e             state_q;
  zsb_job_t           job_q;
  logic [ADDR_W-1:0]  line_q, addr_q, origin;
  logic [OFS_W-1:0]   dx_q, dy_q;
  logic               dx_end, dy_end, out_fire;

  assign pop_o    = (state_q == ST_IDLE) && !fifo_empty_i;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign dx_end   = (dx_q == job_q.zoom_m1);
  assign dy_end   = (dy_q == job_q.zoom_m1);

  // Top-left write of the block, modulo the address width
  assign origin = base_index_i
                + ADDR_W'(ADDR_W'(job_q.row_z) * LINE_STEP)
                + ADDR_W'(job_q.col_z);

  assign m_axis_tvalid   = (state_q == ST_EMIT);
  assign write_address_o = addr_q;
  assign write_color_o   = job_q.color;
  assign last_write_o    = dx_end && dy_end;

  // Sequencer: fetch a job, set up the origin, walk the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
      line_q  <= '0;
      addr_q  <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            job_q   <= job_i;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          line_q  <= origin;
          addr_q  <= origin;
          dx_q    <= '0;
          dy_q    <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (!dx_end) begin
              dx_q   <= dx_q + 1'b1;
              addr_q <= addr_q + 1'b1;
            end else if (!dy_end) begin
              dx_q   <= '0;
              dy_q   <= dy_q + 1'b1;
              line_q <= line_q + LINE_STEP;
              addr_q <= line_q + LINE_STEP;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
